### hdl/wbph_pkg.sv
// Shared types and constants for the baseline-subtracted pulse height block.
`default_nettype none

package wbph_pkg;

  // Field widths fixed by the interface
  localparam int unsigned SampleW  = 16;
  localparam int unsigned ChargeW  = 25;
  localparam int unsigned CfgW     = 7;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned FracW    = 8;
  // |mean| <= 32768 * 256, so 24 magnitude bits
  localparam int unsigned MeanMagW = 24;

  // Defaults for the top-level parameters
  localparam int unsigned DefaultMaxWindow = 64;
  localparam int unsigned DefaultMaxLength = 4096;

  // Queue entries are sized for the largest supported window (1024)
  localparam int unsigned QueueSumW  = 27;
  localparam int unsigned QueueCntW  = 11;
  localparam int unsigned QueueDepth = 2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxInitialCount = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxFinalCount   = 1'b1;

  localparam logic [CfgW-1:0] CfgCountReset = 7'd16;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [ChargeW-1:0] charge;
    logic                      too_short;
  } out_item_t;

  // One finished waveform handed from the front end to the divider
  typedef struct packed {
    logic signed [QueueSumW-1:0] baseline_sum;
    logic signed [QueueSumW-1:0] tail_sum;
    logic [QueueCntW-1:0]        initial_count;
    logic [QueueCntW-1:0]        final_count;
    logic                        too_short;
  } queue_entry_t;

endpackage

`default_nettype wire

### hdl/waveform_baseline_pulse_height.sv
// Top level of the baseline-subtracted pulse height block.
`default_nettype none

// Takes one digitizer sample per request and, on the request flagged as the
// last sample, returns one result: the mean of the last final_count samples
// minus the mean of the first initial_count samples, signed Q8 (each mean is
// sum*256/count, truncated toward zero). Waveforms shorter than
// initial_count + final_count samples give charge 0 with too_short set.
// Count registers read 0 as 1 and clip at MAX_WINDOW; write them only while
// the block is idle. Rate: the front end takes one sample per clock; the
// baseline sum and a sliding tail sum are kept on the fly (the tail window is
// one memory, one write and one read per sample). Each finished waveform
// goes through a two-entry queue to a bit-serial divider that works out the
// baseline mean and then the tail mean, SUM_W+8 quotient bits each, with
// SUM_W = 16+log2(MAX_WINDOW)+1. Waveforms no shorter than the divider's
// time per waveform stream at one sample per clock; a run of shorter ones
// back-pressures the input once the queue fills. With the divider free, the
// last sample passes the stage 2 registers, the queue, both divisions and
// the result register before the result is valid.

module waveform_baseline_pulse_height #(
  parameter int unsigned MAX_WINDOW = wbph_pkg::DefaultMaxWindow,
  parameter int unsigned MAX_LENGTH = wbph_pkg::DefaultMaxLength
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [wbph_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [wbph_pkg::CfgW-1:0]     cfg_data_i,
  // sample requests
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire wbph_pkg::in_item_t            in_data_i,
  // results
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output wbph_pkg::out_item_t                out_data_o
);

  logic [wbph_pkg::CfgW-1:0] cfg_initial_q, cfg_final_q;

  // Register file: two count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_initial_q <= wbph_pkg::CfgCountReset;
      cfg_final_q   <= wbph_pkg::CfgCountReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == wbph_pkg::CfgIdxInitialCount) begin
        cfg_initial_q <= cfg_data_i;
      end else if (cfg_index_i == wbph_pkg::CfgIdxFinalCount) begin
        cfg_final_q <= cfg_data_i;
      end
    end
  end

  logic                   q_push, q_pop, q_full, q_empty;
  wbph_pkg::queue_entry_t q_in, q_head;

  // Front end: per-sample sums and tail window
  wbph_front #(
    .MaxWindow(MAX_WINDOW),
    .MaxLength(MAX_LENGTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_initial_i (cfg_initial_q),
    .cfg_final_i   (cfg_final_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .q_push_o      (q_push),
    .q_full_i      (q_full),
    .q_entry_o     (q_in)
  );

  // Finished waveforms waiting for the divider
  wbph_fifo #(
    .Depth(wbph_pkg::QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // Back end: divider and result register
  wbph_back #(
    .MaxWindow(MAX_WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_entry_i   (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### hdl/wbph_front.sv
// Front end: per-sample accumulation, tail window memory and sliding tail sum.
`default_nettype none

module wbph_front #(
  parameter int unsigned MaxWindow = wbph_pkg::DefaultMaxWindow,
  parameter int unsigned MaxLength = wbph_pkg::DefaultMaxLength
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [wbph_pkg::CfgW-1:0]   cfg_initial_i,
  input  wire logic [wbph_pkg::CfgW-1:0]   cfg_final_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire wbph_pkg::in_item_t          in_data_i,
  output logic                             q_push_o,
  input  wire logic                        q_full_i,
  output wbph_pkg::queue_entry_t           q_entry_o
);

  localparam int unsigned PtrW  = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int unsigned AddrW = PtrW + 1;
  localparam int unsigned NW    = $clog2(MaxWindow + 1);
  localparam int unsigned LW    = $clog2(MaxLength + 1);
  localparam int unsigned SumW  = wbph_pkg::SampleW + $clog2(MaxWindow) + 1;

  function automatic logic [NW-1:0] clamp_count(input logic [wbph_pkg::CfgW-1:0] v);
    logic [NW-1:0] r;
    if (v == '0) begin
      r = NW'(1);
    end else if (32'(v) > MaxWindow) begin
      r = NW'(MaxWindow);
    end else begin
      r = NW'(v);
    end
    return r;
  endfunction

  logic [NW-1:0] n, m;
  assign n = clamp_count(cfg_initial_i);
  assign m = clamp_count(cfg_final_i);

  // Window storage
  logic signed [wbph_pkg::SampleW-1:0] win_mem [MaxWindow];
  logic signed [wbph_pkg::SampleW-1:0] evict_data_q;

  // Stage 1 state
  logic [LW-1:0]          count_q;
  logic signed [SumW-1:0] bl_q;
  logic [PtrW-1:0]        ptr_q;

  // Stage 2 (tail update) registers
  logic                                s2_valid_q, s2_last_q;
  logic signed [wbph_pkg::SampleW-1:0] s2_sample_q;
  logic                                s2_evict_q, s2_short_q;
  logic signed [SumW-1:0]              s2_bl_q;
  logic [NW-1:0]                       s2_n_q, s2_m_q;
  logic signed [SumW-1:0]              tail_q;

  logic                   accept, s2_adv;
  logic [LW-1:0]          count_next;
  logic signed [SumW-1:0] bl_next, tail_next, evict_ext;
  logic [PtrW-1:0]        ptr_next, ev_addr;
  logic [AddrW-1:0]       ev_sum;
  logic                   take_base, evict, short_d;

  assign s2_adv     = s2_valid_q && (!s2_last_q || !q_full_i);
  assign in_ready_o = !s2_valid_q || s2_adv;
  assign accept     = in_valid_i && in_ready_o;

  assign count_next = (32'(count_q) < MaxLength) ? count_q + LW'(1) : count_q;
  assign take_base  = 32'(count_q) < 32'(n);
  assign bl_next    = bl_q + (take_base ? SumW'(in_data_i.sample) : SumW'(0));
  assign evict      = 32'(count_q) >= 32'(m);
  assign short_d    = 32'(count_next) < (32'(n) + 32'(m));
  assign ptr_next   = (32'(ptr_q) == MaxWindow - 1) ? '0 : ptr_q + PtrW'(1);

  // Slot of the sample that drops out of the tail window: ptr - m, modulo window
  assign ev_sum  = {1'b0, ptr_q} + AddrW'(MaxWindow) - AddrW'(m);
  assign ev_addr = (32'(ev_sum) >= MaxWindow) ? PtrW'(ev_sum - AddrW'(MaxWindow))
                                              : PtrW'(ev_sum);

  assign evict_ext = s2_evict_q ? SumW'(evict_data_q) : SumW'(0);
  assign tail_next = tail_q + SumW'(s2_sample_q) - evict_ext;

  // Read-before-write: with a full-size window the evicted slot is the one written
  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_mem[ptr_q] <= in_data_i.sample;
      evict_data_q   <= win_mem[ev_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_sample_q <= in_data_i.sample;
      s2_evict_q  <= evict;
      s2_short_q  <= short_d;
      s2_bl_q     <= bl_next;
      s2_n_q      <= n;
      s2_m_q      <= m;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      bl_q       <= '0;
      ptr_q      <= '0;
      tail_q     <= '0;
      s2_valid_q <= 1'b0;
      s2_last_q  <= 1'b0;
    end else begin
      if (accept) begin
        s2_valid_q <= 1'b1;
        s2_last_q  <= in_data_i.last_sample;
        if (in_data_i.last_sample) begin
          count_q <= '0;
          bl_q    <= '0;
          ptr_q   <= '0;
        end else begin
          count_q <= count_next;
          bl_q    <= bl_next;
          ptr_q   <= ptr_next;
        end
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_adv) begin
        tail_q <= s2_last_q ? SumW'(0) : tail_next;
      end
    end
  end

  assign q_push_o                = s2_adv && s2_last_q;
  assign q_entry_o.baseline_sum  = wbph_pkg::QueueSumW'(s2_bl_q);
  assign q_entry_o.tail_sum      = wbph_pkg::QueueSumW'(tail_next);
  assign q_entry_o.initial_count = wbph_pkg::QueueCntW'(s2_n_q);
  assign q_entry_o.final_count   = wbph_pkg::QueueCntW'(s2_m_q);
  assign q_entry_o.too_short     = s2_short_q;

endmodule

`default_nettype wire

### hdl/wbph_fifo.sv
// Short queue of finished waveforms between the front end and the divider.
`default_nettype none

module wbph_fifo #(
  parameter int unsigned Depth = wbph_pkg::QueueDepth
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_i,
  input  wire wbph_pkg::queue_entry_t  push_data_i,
  input  wire logic                    pop_i,
  output wbph_pkg::queue_entry_t       head_o,
  output logic                         full_o,
  output logic                         empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  wbph_pkg::queue_entry_t entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = 32'(count_q) == Depth;
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == Depth - 1) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == Depth - 1) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### hdl/wbph_back.sv
// Back end: bit-serial division of both sums into Q8 means and the result register.
`default_nettype none

module wbph_back #(
  parameter int unsigned MaxWindow = wbph_pkg::DefaultMaxWindow
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    q_empty_i,
  input  wire wbph_pkg::queue_entry_t  q_entry_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output wbph_pkg::out_item_t          out_data_o
);

  localparam int unsigned NW    = $clog2(MaxWindow + 1);
  localparam int unsigned SumW  = wbph_pkg::SampleW + $clog2(MaxWindow) + 1;
  localparam int unsigned DivW  = SumW + wbph_pkg::FracW;
  localparam int unsigned IterW = $clog2(DivW + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_BASE,
    ST_DIV_TAIL,
    ST_DONE
  } state_e;

  // |v| * 256 as an unsigned dividend
  function automatic logic [DivW-1:0] scaled_mag(input logic signed [SumW-1:0] v);
    logic [SumW-1:0] mag;
    mag = v[SumW-1] ? SumW'(-v) : SumW'(v);
    return {mag, wbph_pkg::FracW'(0)};
  endfunction

  state_e                              state_q;
  logic [NW-1:0]                       rem_q, divisor_q, m_q;
  logic [DivW-1:0]                     quo_q;
  logic [IterW-1:0]                    iter_q;
  logic                                neg_q;
  logic signed [SumW-1:0]              tail_sum_q;
  logic signed [wbph_pkg::ChargeW-1:0] base_mean_q;
  wbph_pkg::out_item_t                 res_q, out_q;
  logic                                out_valid_q;

  logic [NW:0]                         shifted;
  logic                                ge;
  logic [NW-1:0]                       rem_step;
  logic [DivW-1:0]                     quo_step;
  logic [wbph_pkg::ChargeW-1:0]        mag_ext;
  logic signed [wbph_pkg::ChargeW-1:0] mean_val;
  logic signed [SumW-1:0]              base_in;

  // One restoring-division step per cycle
  assign shifted  = {rem_q, quo_q[DivW-1]};
  assign ge       = shifted >= {1'b0, divisor_q};
  assign rem_step = ge ? NW'(shifted - {1'b0, divisor_q}) : NW'(shifted);
  assign quo_step = {quo_q[DivW-2:0], ge};
  assign mag_ext  = wbph_pkg::ChargeW'(quo_step[wbph_pkg::MeanMagW-1:0]);
  assign mean_val = neg_q ? -$signed(mag_ext) : $signed(mag_ext);
  assign base_in  = SumW'(q_entry_i.baseline_sum);

  assign q_pop_o     = (state_q == ST_IDLE) && !q_empty_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rem_q       <= '0;
      divisor_q   <= '0;
      m_q         <= '0;
      quo_q       <= '0;
      iter_q      <= '0;
      neg_q       <= 1'b0;
      tail_sum_q  <= '0;
      base_mean_q <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            if (q_entry_i.too_short) begin
              res_q.charge    <= '0;
              res_q.too_short <= 1'b1;
              state_q         <= ST_DONE;
            end else begin
              neg_q      <= base_in[SumW-1];
              quo_q      <= scaled_mag(base_in);
              rem_q      <= '0;
              divisor_q  <= NW'(q_entry_i.initial_count);
              m_q        <= NW'(q_entry_i.final_count);
              tail_sum_q <= SumW'(q_entry_i.tail_sum);
              iter_q     <= IterW'(DivW - 1);
              state_q    <= ST_DIV_BASE;
            end
          end
        end
        ST_DIV_BASE: begin
          rem_q  <= rem_step;
          quo_q  <= quo_step;
          iter_q <= iter_q - IterW'(1);
          if (iter_q == '0) begin
            base_mean_q <= mean_val;
            neg_q       <= tail_sum_q[SumW-1];
            quo_q       <= scaled_mag(tail_sum_q);
            rem_q       <= '0;
            divisor_q   <= m_q;
            iter_q      <= IterW'(DivW - 1);
            state_q     <= ST_DIV_TAIL;
          end
        end
        ST_DIV_TAIL: begin
          rem_q  <= rem_step;
          quo_q  <= quo_step;
          iter_q <= iter_q - IterW'(1);
          if (iter_q == '0) begin
            res_q.charge    <= mean_val - base_mean_q;
            res_q.too_short <= 1'b0;
            state_q         <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
